// ----- sv/bilrs_pkg.sv -----
// Shared constants, types and helpers for the bilinear RGBA8 resizer.
// Used by the channel interfaces, the coordinate divider, the blend lanes
// and the top level. No dependencies.
package bilrs_pkg;

	// Frame store geometry
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int XW         = $clog2(MAX_WIDTH);
	localparam int YW         = $clog2(MAX_HEIGHT);
	localparam int IW         = (XW > YW) ? XW : YW;
	localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW         = $clog2(DEPTH);

	// Field and register widths
	localparam int POS_W  = 10;
	localparam int SRC_W  = 9;
	localparam int DEN_W  = 11;
	localparam int FRAC_W = 8;
	localparam int CH_W   = 8;
	localparam int NUM_CH = 4;
	localparam int PIX_W  = CH_W * NUM_CH;

	// Divider sizing: quotient is index and fraction, two bits resolved per cycle
	localparam int QW    = IW + FRAC_W;
	localparam int QPAD  = ((QW + 1) / 2) * 2;
	localparam int NCYC  = QPAD / 2;
	localparam int CNT_W = $clog2(NCYC + 1);

	// Register map
	localparam int REG_IDX_W = 3;
	localparam int PADDR_W   = REG_IDX_W + 2;
	localparam logic [REG_IDX_W-1:0] REG_SRC_W = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SRC_H = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DST_W = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DST_H = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_FLIP  = 3'd4;

	// Divider status toward the sequencer
	typedef struct packed {
		logic          idle;
		logic [QW-1:0] quot;
	} div_stat_t;

	// Last valid index of a source size saturated to 1..max_size
	function automatic logic [IW-1:0] last_index(input logic [SRC_W-1:0] size,
		input int max_size);
		logic [IW-1:0] idx;
		if (size == '0) begin
			idx = '0;
		end else if (32'(size) > max_size) begin
			idx = IW'(max_size - 1);
		end else begin
			idx = IW'(32'(size) - 1);
		end
		return idx;
	endfunction

	// Frame store word address of a pixel
	function automatic logic [AW-1:0] pix_addr(input logic [31:0] r, input logic [31:0] c);
		return AW'(r * 32'(MAX_WIDTH) + c);
	endfunction

endpackage

// ----- sv/bilrs_ifs.sv -----
// Valid/ready channel interfaces of the resizer: pixel items in, results out.
// Depends on bilrs_pkg for the field widths.
interface bilrs_in_if;
	logic                           valid;
	logic                           ready;
	logic                           kind;
	logic [bilrs_pkg::POS_W-1:0]    col;
	logic [bilrs_pkg::POS_W-1:0]    row;
	logic [bilrs_pkg::CH_W-1:0]     red;
	logic [bilrs_pkg::CH_W-1:0]     green;
	logic [bilrs_pkg::CH_W-1:0]     blue;
	logic [bilrs_pkg::CH_W-1:0]     alpha;

	modport source (output valid, kind, col, row, red, green, blue, alpha, input ready);
	modport sink (input valid, kind, col, row, red, green, blue, alpha, output ready);
endinterface

interface bilrs_out_if;
	logic                           valid;
	logic                           ready;
	logic [bilrs_pkg::CH_W-1:0]     out_red;
	logic [bilrs_pkg::CH_W-1:0]     out_green;
	logic [bilrs_pkg::CH_W-1:0]     out_blue;
	logic [bilrs_pkg::CH_W-1:0]     out_alpha;
	logic                           bad_coordinate;

	modport source (output valid, out_red, out_green, out_blue, out_alpha, bad_coordinate,
		input ready);
	modport sink (input valid, out_red, out_green, out_blue, out_alpha, bad_coordinate,
		output ready);
endinterface

// ----- sv/bilinear_rgba8_resizer.sv -----
// Bilinear RGBA8 resizer top level: frame store, sequencer, merge stage.
// Depends on bilrs_pkg, bilrs_ifs, bilrs_div and bilrs_lane.
//
// Usage. pix_in carries items: kind 0 stores a source pixel at (col,row),
// dropped when outside the source size; kind 1 requests output pixel
// (col,row). Every request gives exactly one transfer on pix_out; writes give
// none. The APB port sets source size, output size and vertical flip; write
// it only while no request is in flight.
// Flow. A write is stored as it is taken. A request in range passes the two
// coordinate dividers (two quotient bits a cycle), neighbor address forming,
// four single-port frame store reads, then capture, the lane blend and the
// merge into the output register. A request outside the output size goes
// straight to the merge. One item is worked on at a time; pix_in is ready
// again as the result loads.
// Stall. A result waits in the output register while pix_out is stalled;
// writes are still taken then, the next request holds at the merge step.
// Reset. arst_n clears the sequencer and restores register defaults; the
// frame store keeps whatever it held and has no clearing pass.
module bilinear_rgba8_resizer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bilrs_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	bilrs_in_if.sink                      pix_in,
	bilrs_out_if.source                   pix_out
);
	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_DIV   = 7'b0000010,
		ST_ADDR  = 7'b0000100,
		ST_READ  = 7'b0001000,
		ST_BLEND = 7'b0010000,
		ST_LANE  = 7'b0100000,
		ST_MERGE = 7'b1000000
	} state_t;

	localparam logic [1:0] RD_LAST = 2'd3;

	// Configuration registers
	logic [bilrs_pkg::SRC_W-1:0] src_w_q;
	logic [bilrs_pkg::SRC_W-1:0] src_h_q;
	logic [bilrs_pkg::DEN_W-1:0] dst_w_q;
	logic [bilrs_pkg::DEN_W-1:0] dst_h_q;
	logic                        flip_q;
	logic                        cfg_we;
	logic [bilrs_pkg::REG_IDX_W-1:0] reg_idx;

	// Derived geometry
	logic [bilrs_pkg::IW-1:0]    x_last;
	logic [bilrs_pkg::IW-1:0]    y_last;
	logic [bilrs_pkg::DEN_W-1:0] x_den;
	logic [bilrs_pkg::DEN_W-1:0] y_den;

	// Item intake
	logic in_acc;
	logic req_bad;
	logic wr_ok;
	logic div_start;
	logic mem_we;
	logic [bilrs_pkg::AW-1:0] waddr;

	// Dividers
	bilrs_pkg::div_stat_t x_stat;
	bilrs_pkg::div_stat_t y_stat;

	// Neighbor coordinates
	logic [bilrs_pkg::IW-1:0]     x_int;
	logic [bilrs_pkg::IW-1:0]     y_int;
	logic [bilrs_pkg::FRAC_W-1:0] fx_n;
	logic [bilrs_pkg::FRAC_W-1:0] fy_n;
	logic [bilrs_pkg::IW-1:0]     x0;
	logic [bilrs_pkg::IW-1:0]     x1;
	logic [bilrs_pkg::IW-1:0]     y0;
	logic [bilrs_pkg::IW-1:0]     y1;
	logic [bilrs_pkg::IW-1:0]     y0_f;
	logic [bilrs_pkg::IW-1:0]     y1_f;

	// Sequencer and datapath registers
	state_t                       state_q;
	logic [1:0]                   rd_cnt_q;
	logic                         rd_vld_s1;
	logic [1:0]                   rd_sel_s1;
	logic                         bad_req_q;
	logic [bilrs_pkg::AW-1:0]     addr_q [4];
	logic [bilrs_pkg::FRAC_W-1:0] fx_q;
	logic [bilrs_pkg::FRAC_W-1:0] fy_q;
	logic [bilrs_pkg::PIX_W-1:0]  pix_q [4];
	logic [bilrs_pkg::PIX_W-1:0]  rd_s1;
	logic [bilrs_pkg::PIX_W-1:0]  mem [bilrs_pkg::DEPTH];

	// Lanes and output register
	logic [bilrs_pkg::CH_W-1:0]   lane_val [bilrs_pkg::NUM_CH];
	logic                         out_load;
	logic                         out_valid_q;
	logic [bilrs_pkg::CH_W-1:0]   out_ch_q [bilrs_pkg::NUM_CH];
	logic                         out_bad_q;

	// APB register writes
	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite;
	assign reg_idx = paddr[bilrs_pkg::PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= bilrs_pkg::SRC_W'(256);
			src_h_q <= bilrs_pkg::SRC_W'(256);
			dst_w_q <= bilrs_pkg::DEN_W'(256);
			dst_h_q <= bilrs_pkg::DEN_W'(256);
			flip_q  <= 1'b1;
		end else if (cfg_we) begin
			unique case (reg_idx)
				bilrs_pkg::REG_SRC_W: src_w_q <= pwdata[bilrs_pkg::SRC_W-1:0];
				bilrs_pkg::REG_SRC_H: src_h_q <= pwdata[bilrs_pkg::SRC_W-1:0];
				bilrs_pkg::REG_DST_W: dst_w_q <= pwdata[bilrs_pkg::DEN_W-1:0];
				bilrs_pkg::REG_DST_H: dst_h_q <= pwdata[bilrs_pkg::DEN_W-1:0];
				bilrs_pkg::REG_FLIP:  flip_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	// APB register reads
	always_comb begin
		unique case (reg_idx)
			bilrs_pkg::REG_SRC_W: prdata = 32'(src_w_q);
			bilrs_pkg::REG_SRC_H: prdata = 32'(src_h_q);
			bilrs_pkg::REG_DST_W: prdata = 32'(dst_w_q);
			bilrs_pkg::REG_DST_H: prdata = 32'(dst_h_q);
			bilrs_pkg::REG_FLIP:  prdata = 32'(flip_q);
			default:              prdata = '0;
		endcase
	end

	// Saturated source extent and mapping denominators
	assign x_last = bilrs_pkg::last_index(src_w_q, bilrs_pkg::MAX_WIDTH);
	assign y_last = bilrs_pkg::last_index(src_h_q, bilrs_pkg::MAX_HEIGHT);
	assign x_den  = dst_w_q - 1'b1;
	assign y_den  = dst_h_q - 1'b1;

	// Intake: writes go straight to the frame store, requests in range start the dividers
	assign pix_in.ready = (state_q == ST_IDLE);
	assign in_acc       = pix_in.valid && pix_in.ready;
	assign req_bad      = ({1'b0, pix_in.col} >= dst_w_q) || ({1'b0, pix_in.row} >= dst_h_q);
	assign wr_ok        = (32'(pix_in.col) <= 32'(x_last)) && (32'(pix_in.row) <= 32'(y_last));
	assign div_start    = in_acc && pix_in.kind && !req_bad;
	assign mem_we       = in_acc && !pix_in.kind && wr_ok;
	assign waddr        = bilrs_pkg::pix_addr(32'(pix_in.row), 32'(pix_in.col));

	bilrs_div u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.pos    (pix_in.col),
		.last   (x_last),
		.den    (x_den),
		.stat   (x_stat)
	);

	bilrs_div u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.pos    (pix_in.row),
		.last   (y_last),
		.den    (y_den),
		.stat   (y_stat)
	);

	// Split quotients, clamp neighbors at the edge, flip rows
	always_comb begin
		if (x_den == '0) begin
			x_int = '0;
			fx_n  = '0;
		end else begin
			x_int = x_stat.quot[bilrs_pkg::QW-1:bilrs_pkg::FRAC_W];
			fx_n  = x_stat.quot[bilrs_pkg::FRAC_W-1:0];
		end
		if (y_den == '0) begin
			y_int = '0;
			fy_n  = '0;
		end else begin
			y_int = y_stat.quot[bilrs_pkg::QW-1:bilrs_pkg::FRAC_W];
			fy_n  = y_stat.quot[bilrs_pkg::FRAC_W-1:0];
		end
		x0   = (x_int > x_last) ? x_last : x_int;
		y0   = (y_int > y_last) ? y_last : y_int;
		x1   = (x0 < x_last) ? x0 + 1'b1 : x_last;
		y1   = (y0 < y_last) ? y0 + 1'b1 : y_last;
		y0_f = flip_q ? y_last - y0 : y0;
		y1_f = flip_q ? y_last - y1 : y1;
	end

	// Frame store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= {pix_in.alpha, pix_in.blue, pix_in.green, pix_in.red};
		end
		rd_s1 <= mem[addr_q[rd_cnt_q]];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_cnt_q  <= '0;
			rd_vld_s1 <= 1'b0;
			rd_sel_s1 <= '0;
			bad_req_q <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_READ);
			rd_sel_s1 <= rd_cnt_q;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && pix_in.kind) begin
						bad_req_q <= req_bad;
						state_q   <= req_bad ? ST_MERGE : ST_DIV;
					end
				end
				ST_DIV: begin
					if (x_stat.idle && y_stat.idle) begin
						state_q <= ST_ADDR;
					end
				end
				ST_ADDR: begin
					rd_cnt_q <= '0;
					state_q  <= ST_READ;
				end
				ST_READ: begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
					if (rd_cnt_q == RD_LAST) begin
						state_q <= ST_BLEND;
					end
				end
				ST_BLEND: state_q <= ST_LANE;
				ST_LANE:  state_q <= ST_MERGE;
				ST_MERGE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Latch neighbor addresses and fractions, capture fetched pixels
	always_ff @(posedge clk) begin
		if (state_q == ST_ADDR) begin
			addr_q[0] <= bilrs_pkg::pix_addr(32'(y0_f), 32'(x0));
			addr_q[1] <= bilrs_pkg::pix_addr(32'(y0_f), 32'(x1));
			addr_q[2] <= bilrs_pkg::pix_addr(32'(y1_f), 32'(x0));
			addr_q[3] <= bilrs_pkg::pix_addr(32'(y1_f), 32'(x1));
			fx_q      <= fx_n;
			fy_q      <= fy_n;
		end
		if (rd_vld_s1) begin
			pix_q[rd_sel_s1] <= rd_s1;
		end
	end

	// One blend lane per channel
	for (genvar c = 0; c < bilrs_pkg::NUM_CH; c++) begin : g_lane
		bilrs_lane u_lane (
			.clk   (clk),
			.p00   (pix_q[0][c*bilrs_pkg::CH_W +: bilrs_pkg::CH_W]),
			.p10   (pix_q[1][c*bilrs_pkg::CH_W +: bilrs_pkg::CH_W]),
			.p01   (pix_q[2][c*bilrs_pkg::CH_W +: bilrs_pkg::CH_W]),
			.p11   (pix_q[3][c*bilrs_pkg::CH_W +: bilrs_pkg::CH_W]),
			.fx    (fx_q),
			.fy    (fy_q),
			.value (lane_val[c])
		);
	end

	// Merge lanes into the output register once it is free
	assign out_load = (state_q == ST_MERGE) && (!out_valid_q || pix_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (pix_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			for (int c = 0; c < bilrs_pkg::NUM_CH; c++) begin
				out_ch_q[c] <= bad_req_q ? '0 : lane_val[c];
			end
			out_bad_q <= bad_req_q;
		end
	end

	assign pix_out.valid          = out_valid_q;
	assign pix_out.out_red        = out_ch_q[0];
	assign pix_out.out_green      = out_ch_q[1];
	assign pix_out.out_blue       = out_ch_q[2];
	assign pix_out.out_alpha      = out_ch_q[3];
	assign pix_out.bad_coordinate = out_bad_q;

`ifndef NO_ASSERTIONS
	// Both dividers have finished before their quotients are used
	a_addr_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ADDR |-> x_stat.idle && y_stat.idle)
		else $error("neighbor addresses formed from a busy divider");

	// Blend starts only after the fourth read, whose data is being captured
	a_blend_after_reads: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BLEND |-> $past(state_q) == ST_READ && $past(rd_cnt_q) == RD_LAST
		&& rd_vld_s1)
		else $error("blend entered before all four pixels were fetched");

	// A pending result is never overwritten by the next one
	a_merge_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MERGE && out_valid_q && !pix_out.ready
		|=> state_q == ST_MERGE && out_valid_q)
		else $error("merge did not wait for the output register");

	// Frame store is written only by a pixel write taken while idle
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> state_q == ST_IDLE && !pix_in.kind && !div_start)
		else $error("frame store written outside an idle pixel write");
`endif

endmodule

// ----- sv/bilrs_div.sv -----
// Iterative coordinate mapper: (pos*last*256)/den by restoring division,
// two quotient bits a cycle. Quotient holds source index and 8-bit fraction.
// Depends on bilrs_pkg.
module bilrs_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [bilrs_pkg::POS_W-1:0] pos,
	input  logic [bilrs_pkg::IW-1:0]    last,
	input  logic [bilrs_pkg::DEN_W-1:0] den,
	output bilrs_pkg::div_stat_t        stat
);
	localparam int PW = bilrs_pkg::POS_W + bilrs_pkg::IW;
	localparam int DW = PW + bilrs_pkg::FRAC_W;
	localparam int RW = bilrs_pkg::DEN_W + 1;

	logic [PW-1:0]               prod;
	logic [DW-1:0]               dvd;
	logic [RW-1:0]               rem_q;
	logic [RW-1:0]               rem_n;
	logic [RW-1:0]               step_r;
	logic [bilrs_pkg::QPAD-1:0]  sh_q;
	logic [bilrs_pkg::QPAD-1:0]  sh_n;
	logic [bilrs_pkg::CNT_W-1:0] cnt_q;

	// Scale the position; the dividend carries eight fraction bits
	always_comb begin
		prod = PW'(pos) * PW'(last);
		dvd  = {prod, bilrs_pkg::FRAC_W'(0)};
	end

	// Resolve two quotient bits: shift in a dividend bit, compare, subtract
	always_comb begin
		rem_n  = rem_q;
		sh_n   = sh_q;
		step_r = '0;
		for (int i = 0; i < 2; i++) begin
			step_r = {rem_n[RW-2:0], sh_n[bilrs_pkg::QPAD-1]};
			if (step_r >= RW'(den)) begin
				rem_n = step_r - RW'(den);
				sh_n  = {sh_n[bilrs_pkg::QPAD-2:0], 1'b1};
			end else begin
				rem_n = step_r;
				sh_n  = {sh_n[bilrs_pkg::QPAD-2:0], 1'b0};
			end
		end
	end

	// Count the remaining iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= bilrs_pkg::CNT_W'(bilrs_pkg::NCYC);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Load the upper dividend part as partial remainder, then iterate
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= RW'(dvd[DW-1:bilrs_pkg::QPAD]);
			sh_q  <= dvd[bilrs_pkg::QPAD-1:0];
		end else if (cnt_q != '0) begin
			rem_q <= rem_n;
			sh_q  <= sh_n;
		end
	end

	assign stat.idle = (cnt_q == '0);
	assign stat.quot = sh_q[bilrs_pkg::QW-1:0];

endmodule

// ----- sv/bilrs_lane.sv -----
// One channel blend lane: horizontal blend of two rows, registered, then the
// vertical blend and the final shift. Depends on bilrs_pkg.
module bilrs_lane (
	input  logic                         clk,
	input  logic [bilrs_pkg::CH_W-1:0]   p00,
	input  logic [bilrs_pkg::CH_W-1:0]   p10,
	input  logic [bilrs_pkg::CH_W-1:0]   p01,
	input  logic [bilrs_pkg::CH_W-1:0]   p11,
	input  logic [bilrs_pkg::FRAC_W-1:0] fx,
	input  logic [bilrs_pkg::FRAC_W-1:0] fy,
	output logic [bilrs_pkg::CH_W-1:0]   value
);
	localparam int WW = bilrs_pkg::FRAC_W + 1;
	localparam int HW = bilrs_pkg::CH_W + bilrs_pkg::FRAC_W;
	localparam int VW = HW + bilrs_pkg::FRAC_W;

	logic [WW-1:0] wx;
	logic [WW-1:0] wy;
	logic [HW-1:0] top_sum;
	logic [HW-1:0] bot_sum;
	logic [HW-1:0] top_s1;
	logic [HW-1:0] bot_s1;
	logic [VW-1:0] vert_sum;

	// Complementary weights 256-f
	assign wx = WW'(1 << bilrs_pkg::FRAC_W) - WW'(fx);
	assign wy = WW'(1 << bilrs_pkg::FRAC_W) - WW'(fy);

	// Blend left and right neighbors of both rows; a blend never exceeds 255*256
	always_comb begin
		top_sum = HW'(p00) * HW'(wx) + HW'(p10) * HW'(fx);
		bot_sum = HW'(p01) * HW'(wx) + HW'(p11) * HW'(fx);
	end

	always_ff @(posedge clk) begin
		top_s1 <= top_sum;
		bot_s1 <= bot_sum;
	end

	// Blend the rows and drop the sixteen fraction bits
	assign vert_sum = VW'(top_s1) * VW'(wy) + VW'(bot_s1) * VW'(fy);
	assign value    = vert_sum[VW-1:HW];

endmodule
